// ===== design/dart_pkg.sv =====
package dart_pkg;

    localparam int ADDR_SPACE_DEFAULT   = 4096;
    localparam int DEVICE_KINDS_DEFAULT = 4;
    localparam int MAX_AMOUNT_RESET     = 960;
    localparam int RUN_AMOUNT_MAX       = 8191;

    typedef enum logic [1:0] {
        STATUS_SUBSCRIBED = 2'd0,
        STATUS_REJECTED   = 2'd1,
        STATUS_FOUND      = 2'd2,
        STATUS_NONE       = 2'd3
    } status_t;

    typedef enum logic {
        OP_SUBSCRIBE = 1'b0,
        OP_QUERY     = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_SUB_WR,
        ST_Q_SCAN,
        ST_RUN,
        ST_DONE
    } state_t;

    // Index of the lowest set bit, found by halving the window six times.
    function automatic logic [5:0] tz64(input logic [63:0] v);
        logic [63:0] x;
        logic [5:0]  n;
        x = v;
        n = 6'd0;
        for (int i = 5; i >= 0; i--)
        begin
            if ((x & ((64'd1 << (1 << i)) - 64'd1)) == 64'd0)
            begin
                n[i] = 1'b1;
                x    = x >> (1 << i);
            end
        end
        return n;
    endfunction

endpackage

// ===== design/dart_ram.sv =====
module dart_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/device_address_run_tracker.sv =====
// Per-device-kind address subscription tracker.
// Input beats (s_axis) carry either a subscribe, which marks a run of
// consecutive addresses in the bitmap of one device kind, or a query, which
// returns the maximal run of marked addresses at or above a search address.
// Each input beat yields exactly one result beat on m_axis.
// The bitmap lives in one memory of 64-bit words; a single sequencer walks it
// one word per cycle. An accepted item is checked and then walks each bitmap
// word it touches; a rejected item touches none. A query that finds a run
// searches the first word of the run again for its end and then sizes the run.
// The result beat turns valid at the edge where s_axis_tready rises again;
// s_axis_tready is high only while the block is idle.
// After reset the memory is zeroed one word per cycle, all DEVICE_KINDS *
// ADDR_SPACE / 64 words (256 by default), before the first item is taken.
// Results sit in an output register; while the receiver stalls the next
// item may still be accepted and worked on, and it waits for the register.
// max_amount is written on the cfg channel, which is always ready.
module device_address_run_tracker #(
    parameter int ADDR_SPACE   = dart_pkg::ADDR_SPACE_DEFAULT,
    parameter int DEVICE_KINDS = dart_pkg::DEVICE_KINDS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // address [11:0], amount [24:12]
    input  logic [2:0]  s_axis_tuser,   // opcode [0], device_kind [2:1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // run_start [11:0], run_amount [24:12]
    output logic [1:0]  m_axis_tuser,   // status [1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data
);

    import dart_pkg::*;

    localparam int WPK   = ADDR_SPACE / 64;
    localparam int WORDS = DEVICE_KINDS * WPK;
    localparam int AW    = $clog2(ADDR_SPACE);
    localparam int AXW   = AW + 1;
    localparam int WW    = (AW > 6) ? AW - 6 : 1;
    localparam int CW    = (AXW > 14) ? AXW : 14;
    localparam int RW    = (AXW > 13) ? AXW : 13;
    localparam int MAW   = (WORDS > 1) ? $clog2(WORDS) : 1;

    state_t          state_reg, state_next;
    opcode_t         opcode_reg, opcode_next;
    logic [1:0]      kind_reg, kind_next;
    logic [11:0]     addr_reg, addr_next;
    logic [12:0]     amount_reg, amount_next;
    logic [MAW-1:0]  base_reg, base_next;
    logic [WW-1:0]   w_reg, w_next;
    logic [WW-1:0]   last_w_reg, last_w_next;
    logic [5:0]      lo_reg, lo_next;
    logic [5:0]      hi_reg, hi_next;
    logic            mode_reg, mode_next;
    logic [AXW-1:0]  start_reg, start_next;
    logic [AXW-1:0]  end_reg, end_next;
    status_t         res_status_reg, res_status_next;
    logic [11:0]     res_start_reg, res_start_next;
    logic [12:0]     res_run_reg, res_run_next;
    logic [MAW-1:0]  clr_reg, clr_next;
    logic [12:0]     max_amount_reg, max_amount_next;
    logic            m_valid_reg, m_valid_next;
    status_t         m_status_reg, m_status_next;
    logic [11:0]     m_start_reg, m_start_next;
    logic [12:0]     m_run_reg, m_run_next;

    logic            wr_en, rd_en;
    logic [MAW-1:0]  wr_addr, rd_addr;
    logic [63:0]     wr_data, rd_data;

    logic            in_fire, out_free;
    logic            kind_ok, sub_ok, qry_ok;
    logic [CW-1:0]   sum, last;
    logic [WW-1:0]   first_w;
    logic            at_sub_last, at_kind_last;
    logic [5:0]      hi_sel, pos;
    logic [63:0]     lo_mask, hi_mask, cand;
    logic            hit;
    logic [AXW-1:0]  bit_addr;
    logic [RW-1:0]   run_full;

    dart_ram #(
        .WIDTH (64),
        .DEPTH (WORDS)
    ) u_bitmap (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;

    assign kind_ok = (32'(kind_reg) < DEVICE_KINDS);
    assign sum     = CW'(addr_reg) + CW'(amount_reg);
    assign last    = sum - CW'(1);
    assign sub_ok  = kind_ok && (amount_reg != 13'd0) && (amount_reg <= max_amount_reg)
                     && (sum <= CW'(ADDR_SPACE));
    assign qry_ok  = kind_ok && (CW'(addr_reg) < CW'(ADDR_SPACE));
    assign first_w = WW'(addr_reg >> 6);

    assign at_sub_last  = (w_reg == last_w_reg);
    assign at_kind_last = (w_reg == WW'(WPK - 1));

    assign lo_mask = {64{1'b1}} << lo_reg;
    assign hi_sel  = at_sub_last ? hi_reg : 6'd63;
    assign hi_mask = {64{1'b1}} >> (6'd63 - hi_sel);

    // Searching for a set bit first, then for the clear bit that ends the run.
    assign cand     = (mode_reg ? ~rd_data : rd_data) & lo_mask;
    assign hit      = |cand;
    assign pos      = tz64(cand);
    assign bit_addr = AXW'({w_reg, pos});
    assign run_full = RW'(end_reg) - RW'(start_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == MAW'(WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (opcode_reg == OP_QUERY)
                begin
                    state_next = qry_ok ? ST_Q_SCAN : ST_DONE;
                end
                else
                begin
                    state_next = sub_ok ? ST_SUB_WR : ST_DONE;
                end
            end
            ST_SUB_WR:
            begin
                if (at_sub_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_Q_SCAN:
            begin
                if (hit && mode_reg)
                begin
                    state_next = ST_RUN;
                end
                else if (!hit && at_kind_last)
                begin
                    state_next = mode_reg ? ST_RUN : ST_DONE;
                end
            end
            ST_RUN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        opcode_next     = opcode_reg;
        kind_next       = kind_reg;
        addr_next       = addr_reg;
        amount_next     = amount_reg;
        base_next       = base_reg;
        w_next          = w_reg;
        last_w_next     = last_w_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mode_next       = mode_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        res_run_next    = res_run_reg;
        clr_next        = clr_reg;
        m_status_next   = m_status_reg;
        m_start_next    = m_start_reg;
        m_run_next      = m_run_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        max_amount_next = cfg_valid ? cfg_data : max_amount_reg;
        wr_en           = 1'b0;
        wr_addr         = base_reg + MAW'(w_reg);
        wr_data         = rd_data | (lo_mask & hi_mask);
        rd_en           = 1'b0;
        rd_addr         = base_reg + MAW'(first_w);

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = 64'd0;
                clr_next = clr_reg + MAW'(1);
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    opcode_next = opcode_t'(s_axis_tuser[0]);
                    kind_next   = s_axis_tuser[2:1];
                    addr_next   = s_axis_tdata[11:0];
                    amount_next = s_axis_tdata[24:12];
                    base_next   = MAW'(32'(s_axis_tuser[2:1]) * WPK);
                end
            end
            ST_CHECK:
            begin
                w_next         = first_w;
                last_w_next    = WW'(last >> 6);
                lo_next        = addr_reg[5:0];
                hi_next        = last[5:0];
                mode_next      = 1'b0;
                res_start_next = 12'd0;
                res_run_next   = 13'd0;
                if (opcode_reg == OP_QUERY)
                begin
                    rd_en           = qry_ok;
                    res_status_next = STATUS_NONE;
                end
                else
                begin
                    rd_en           = sub_ok;
                    res_status_next = STATUS_REJECTED;
                end
            end
            ST_SUB_WR:
            begin
                wr_en = 1'b1;
                if (at_sub_last)
                begin
                    res_status_next = STATUS_SUBSCRIBED;
                end
                else
                begin
                    w_next  = w_reg + WW'(1);
                    lo_next = 6'd0;
                    rd_en   = 1'b1;
                    rd_addr = base_reg + MAW'(w_reg + WW'(1));
                end
            end
            ST_Q_SCAN:
            begin
                if (hit)
                begin
                    if (mode_reg)
                    begin
                        end_next = bit_addr;
                    end
                    else
                    begin
                        // Run starts here; look for its end in the same word.
                        start_next = bit_addr;
                        mode_next  = 1'b1;
                        lo_next    = pos;
                    end
                end
                else if (at_kind_last)
                begin
                    end_next = AXW'(ADDR_SPACE);
                end
                else
                begin
                    w_next  = w_reg + WW'(1);
                    lo_next = 6'd0;
                    rd_en   = 1'b1;
                    rd_addr = base_reg + MAW'(w_reg + WW'(1));
                end
            end
            ST_RUN:
            begin
                res_status_next = STATUS_FOUND;
                res_start_next  = 12'(start_reg);
                if (run_full > RW'(RUN_AMOUNT_MAX))
                begin
                    res_run_next = 13'(RUN_AMOUNT_MAX);
                end
                else
                begin
                    res_run_next = 13'(run_full);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_start_next  = res_start_reg;
                    m_run_next    = res_run_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            m_valid_reg    <= 1'b0;
            max_amount_reg <= 13'(MAX_AMOUNT_RESET);
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            m_valid_reg    <= m_valid_next;
            max_amount_reg <= max_amount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opcode_reg     <= opcode_next;
        kind_reg       <= kind_next;
        addr_reg       <= addr_next;
        amount_reg     <= amount_next;
        base_reg       <= base_next;
        w_reg          <= w_next;
        last_w_reg     <= last_w_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mode_reg       <= mode_next;
        start_reg      <= start_next;
        end_reg        <= end_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        res_run_reg    <= res_run_next;
        m_status_reg   <= m_status_next;
        m_start_reg    <= m_start_next;
        m_run_reg      <= m_run_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, m_run_reg, m_start_reg};
    assign m_axis_tuser  = m_status_reg;

endmodule

// ===== test/dart_run_checker.sv =====
`timescale 1ns / 1ps

// Watches the item, result and register channels of the run tracker, keeps its
// own copy of the subscription bitmaps, and compares every result beat with
// the oldest outstanding prediction.
module dart_run_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // address [11:0], amount [24:12]
    input  logic [2:0]  s_axis_tuser,   // opcode [0], device_kind [2:1]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // run_start [11:0], run_amount [24:12]
    input  logic [1:0]  m_axis_tuser,   // status [1:0]
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [12:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          subscribed_count,
    output int          rejected_count,
    output int          found_count,
    output int          empty_count
);

    import dart_pkg::*;

    localparam int ADDR_SPACE = ADDR_SPACE_DEFAULT;
    localparam int KINDS      = DEVICE_KINDS_DEFAULT;

    typedef struct packed {
        status_t     status;
        logic [11:0] run_start;
        logic [12:0] run_amount;
    } run_result_t;

    logic [ADDR_SPACE-1:0] subscribed_map [KINDS];
    logic [12:0]           amount_limit;
    run_result_t           expected_runs [$];
    run_result_t           want;
    run_result_t           predicted;

    // Applies one item to the local bitmaps and returns the result it must give.
    function automatic run_result_t predict_run_result(input opcode_t op,
                                                       input logic [1:0] kind,
                                                       input logic [11:0] addr,
                                                       input logic [12:0] amt);
        run_result_t r;
        int          base;
        int          count;
        int          a;
        int          e;
        base         = addr;
        count        = amt;
        r.status     = STATUS_NONE;
        r.run_start  = 12'd0;
        r.run_amount = 13'd0;
        if (op == OP_SUBSCRIBE)
        begin
            if (count == 0 || amt > amount_limit || base + count > ADDR_SPACE)
            begin
                r.status = STATUS_REJECTED;
            end
            else
            begin
                for (a = base; a < base + count; a++)
                    subscribed_map[kind][a] = 1'b1;
                r.status = STATUS_SUBSCRIBED;
            end
        end
        else
        begin
            a = base;
            while (a < ADDR_SPACE && !subscribed_map[kind][a])
                a++;
            if (a < ADDR_SPACE)
            begin
                e = a;
                while (e < ADDR_SPACE && subscribed_map[kind][e])
                    e++;
                r.status     = STATUS_FOUND;
                r.run_start  = 12'(a);
                r.run_amount = 13'(e - a);
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < KINDS; k++)
                subscribed_map[k] = '0;
            amount_limit = 13'(MAX_AMOUNT_RESET);
            expected_runs.delete();
            fail_count       = 0;
            pending          = 0;
            subscribed_count = 0;
            rejected_count   = 0;
            found_count      = 0;
            empty_count      = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                amount_limit = cfg_data;

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_runs.size() == 0)
                begin
                    $error("result beat with nothing outstanding: status %0d start %0d %s %0d",
                           m_axis_tuser, m_axis_tdata[11:0], "amount",
                           m_axis_tdata[24:12]);
                    fail_count++;
                end
                else
                begin
                    want = expected_runs.pop_front();
                    pending--;
                    if (m_axis_tuser != want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
                        fail_count++;
                    end
                    if (m_axis_tdata[11:0] != want.run_start)
                    begin
                        $error("run_start: expected %0d, actual %0d",
                               want.run_start, m_axis_tdata[11:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[24:12] != want.run_amount)
                    begin
                        $error("run_amount: expected %0d, actual %0d",
                               want.run_amount, m_axis_tdata[24:12]);
                        fail_count++;
                    end
                    case (want.status)
                        STATUS_SUBSCRIBED: subscribed_count++;
                        STATUS_REJECTED:   rejected_count++;
                        STATUS_FOUND:      found_count++;
                        default:           empty_count++;
                    endcase
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                predicted = predict_run_result(opcode_t'(s_axis_tuser[0]),
                                               s_axis_tuser[2:1],
                                               s_axis_tdata[11:0],
                                               s_axis_tdata[24:12]);
                expected_runs.insert(expected_runs.size(), predicted);
                pending++;
            end
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import dart_pkg::*;

    localparam int ADDR_SPACE  = ADDR_SPACE_DEFAULT;
    localparam int PHASE_ITEMS = 260;
    localparam int IDLE_LIMIT  = 2000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // address [11:0], amount [24:12]
    logic [2:0]  s_axis_tuser;   // opcode [0], device_kind [2:1]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;   // run_start [11:0], run_amount [24:12]
    logic [1:0]  m_axis_tuser;   // status [1:0]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [12:0] cfg_data;

    int fail_count;
    int pending;
    int subscribed_count;
    int rejected_count;
    int found_count;
    int empty_count;

    int items_sent    = 0;
    int walks_done    = 0;
    int limit_setting = MAX_AMOUNT_RESET;
    int burst_left    = 0;
    int idle_cycles   = 0;
    int stall_left    = 0;
    bit gaps_on       = 1'b0;
    bit rx_stalls     = 1'b0;

    device_address_run_tracker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    dart_run_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tuser     (s_axis_tuser),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .m_axis_tuser     (m_axis_tuser),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .fail_count       (fail_count),
        .pending          (pending),
        .subscribed_count (subscribed_count),
        .rejected_count   (rejected_count),
        .found_count      (found_count),
        .empty_count      (empty_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The receiver takes beats freely or stalls for random stretches.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (rx_stalls && $urandom_range(0, 99) < 30)
                stall_left = $urandom_range(1, 20);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
                $display("[device_address_run_tracker] ERROR");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is
    // taken, with valid still high so that a following beat can go back to back.
    task automatic send_item(input opcode_t op, input logic [1:0] kind,
                             input logic [11:0] addr, input logic [12:0] amt);
        if (burst_left == 0)
        begin
            if (gaps_on)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, amt, addr};
        s_axis_tuser  <= {kind, op};
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        burst_left--;
        items_sent++;
    endtask

    // Drops valid and waits until every result is back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_max_amount(input int value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= 13'(value);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        limit_setting = value;
    endtask

    // Walks the merged range list of one kind, each query after the first starting
    // where the previous run ended, until the list is exhausted or after 24 queries.
    task automatic walk_kind(input logic [1:0] kind);
        int          next;
        int          steps;
        logic [1:0]  got_status;
        logic [31:0] got_data;
        drain();
        next  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ADDR_SPACE - 1) : 0;
        steps = 0;
        while (next < ADDR_SPACE && steps < 24)
        begin
            send_item(OP_QUERY, kind, 12'(next), 13'($urandom_range(0, 8191)));
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
            got_status = m_axis_tuser;
            got_data   = m_axis_tdata;
            @(negedge clk);
            steps++;
            if (got_status == STATUS_FOUND)
                next = int'(got_data[11:0]) + int'(got_data[24:12]);
            else
                next = ADDR_SPACE;
        end
        burst_left = 0;
        walks_done++;
    endtask

    task automatic random_phase(input int count);
        int         first;
        int         pick;
        int         cap;
        int         amt;
        int         addr;
        logic [1:0] kind;
        first = items_sent;
        while (items_sent - first < count)
        begin
            pick = $urandom_range(0, 99);
            kind = 2'($urandom_range(0, 3));
            cap  = (limit_setting > ADDR_SPACE) ? ADDR_SPACE : limit_setting;
            if (pick < 45)
            begin
                // Mostly short runs so the bitmaps stay sparse enough to merge.
                if (cap == 0)
                    amt = $urandom_range(1, 64);
                else if ($urandom_range(0, 99) < 85)
                    amt = $urandom_range(1, (cap < 16) ? cap : 16);
                else if ($urandom_range(0, 99) < 95)
                    amt = $urandom_range(1, (cap < 256) ? cap : 256);
                else
                    amt = $urandom_range(1, cap);
                addr = $urandom_range(0, ADDR_SPACE - amt);
                send_item(OP_SUBSCRIBE, kind, 12'(addr), 13'(amt));
            end
            else if (pick < 57)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        amt  = 0;
                        addr = $urandom_range(0, ADDR_SPACE - 1);
                    end
                    1:
                    begin
                        if (limit_setting < 8191)
                            amt = $urandom_range(limit_setting + 1, 8191);
                        else
                            amt = 8191;
                        addr = $urandom_range(0, ADDR_SPACE - 1);
                    end
                    default:
                    begin
                        amt  = $urandom_range(2, ADDR_SPACE);
                        addr = $urandom_range(ADDR_SPACE + 1 - amt, ADDR_SPACE - 1);
                    end
                endcase
                send_item(OP_SUBSCRIBE, kind, 12'(addr), 13'(amt));
            end
            else if (pick < 92)
            begin
                send_item(OP_QUERY, kind, 12'($urandom_range(0, ADDR_SPACE - 1)),
                          13'($urandom_range(0, 8191)));
            end
            else
            begin
                walk_kind(kind);
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 32'd0;
        s_axis_tuser  = 3'd0;
        cfg_valid     = 1'b0;
        cfg_data      = 13'd0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed items under the reset limit of 960.
        rx_stalls = 1'b1;
        send_item(OP_QUERY,     2'd0, 12'd0,    13'd0);
        send_item(OP_SUBSCRIBE, 2'd0, 12'd0,    13'd1);
        send_item(OP_SUBSCRIBE, 2'd0, 12'd4095, 13'd1);
        send_item(OP_SUBSCRIBE, 2'd0, 12'd4095, 13'd2);
        send_item(OP_SUBSCRIBE, 2'd1, 12'd7,    13'd0);
        send_item(OP_SUBSCRIBE, 2'd1, 12'd100,  13'd961);
        send_item(OP_SUBSCRIBE, 2'd1, 12'd100,  13'd960);
        send_item(OP_SUBSCRIBE, 2'd1, 12'd1000, 13'd8191);
        send_item(OP_SUBSCRIBE, 2'd2, 12'd10,   13'd5);
        send_item(OP_SUBSCRIBE, 2'd2, 12'd12,   13'd10);
        send_item(OP_SUBSCRIBE, 2'd2, 12'd22,   13'd3);
        send_item(OP_QUERY,     2'd2, 12'd0,    13'd8191);
        send_item(OP_QUERY,     2'd2, 12'd15,   13'd0);
        send_item(OP_QUERY,     2'd2, 12'd25,   13'd0);
        send_item(OP_QUERY,     2'd0, 12'd1,    13'd0);
        send_item(OP_QUERY,     2'd0, 12'd4095, 13'd0);
        send_item(OP_QUERY,     2'd1, 12'd0,    13'd0);
        send_item(OP_QUERY,     2'd3, 12'd4095, 13'd0);
        send_item(OP_SUBSCRIBE, 2'd3, 12'd63,   13'd2);
        send_item(OP_QUERY,     2'd3, 12'd0,    13'd0);
        send_item(OP_SUBSCRIBE, 2'd3, 12'd3136, 13'd960);
        send_item(OP_QUERY,     2'd3, 12'd100,  13'd0);

        gaps_on = 1'b1;
        write_max_amount(1);
        random_phase(PHASE_ITEMS);

        // With a limit of zero every subscribe must bounce.
        rx_stalls = 1'b0;
        write_max_amount(0);
        random_phase(PHASE_ITEMS);

        rx_stalls = 1'b1;
        gaps_on   = 1'b0;
        write_max_amount(8191);
        random_phase(PHASE_ITEMS);

        gaps_on = 1'b1;
        write_max_amount($urandom_range(2, 4095));
        random_phase(PHASE_ITEMS);

        write_max_amount(ADDR_SPACE);
        random_phase(PHASE_ITEMS - 20);
        send_item(OP_SUBSCRIBE, 2'd3, 12'd1, 13'(ADDR_SPACE));
        send_item(OP_SUBSCRIBE, 2'd3, 12'd0, 13'(ADDR_SPACE));
        send_item(OP_QUERY,     2'd3, 12'd0, 13'd0);
        send_item(OP_QUERY,     2'd3, 12'd4095, 13'd0);

        drain();
        repeat (100) @(posedge clk);

        $display("Sent %0d items (%0d range walks): %0d subscribed, %0d rejected,",
                 items_sent, walks_done, subscribed_count, rejected_count);
        $display("%0d runs found and %0d empty queries over six max_amount settings.",
                 found_count, empty_count);
        if (fail_count == 0 && pending == 0)
            $display("[device_address_run_tracker] OK");
        else
            $display("[device_address_run_tracker] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/dart_pkg.sv
design/dart_ram.sv
design/device_address_run_tracker.sv
test/dart_run_checker.sv
test/testbench.sv
